@@ src/vsbd_pkg.sv @@
`default_nettype none

package vsbd_pkg;

    localparam int FIELD_BITS = 24;
    localparam int FPS_BITS   = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = 2;
    localparam int CNT_BITS   = 3;

    // Register indexes on the configuration port (byte address = 4 * index).
    localparam logic [1:0] REG_HIGH_EPS   = 2'd0;
    localparam logic [1:0] REG_LOW_EPS    = 2'd1;
    localparam logic [1:0] REG_ENERGY     = 2'd2;
    localparam logic [1:0] REG_MIN_LENGTH = 2'd3;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] high_eps;
        logic signed [FIELD_BITS-1:0] low_eps;
        logic signed [FIELD_BITS-1:0] energy;
        logic        [FPS_BITS-1:0]   min_length;
    } t_cfg;

    typedef struct packed {
        logic [FIELD_BITS-1:0] frame_index;
        logic                  new_shot;
        logic                  was_uncertain;
    } t_res;

    // One queue entry: the results caused by one input item, in output order.
    typedef struct packed {
        t_res first;
        t_res second;
        logic two;
    } t_pkt;

    typedef struct packed {
        logic push;
        logic full;
    } t_push_ctl;

    typedef struct packed {
        logic pop;
        logic empty;
    } t_pop_ctl;

endpackage

`default_nettype wire

@@ src/video_shot_boundary_detector_unit.sv @@
`default_nettype none

// Shot boundary detector with two epsilon thresholds. Each input item carries
// one frame's features: epsilon in i_s_tdata[23:0] and the energy difference in
// i_s_tdata[47:24], both signed Q16.8, with i_s_tlast marking the final frame
// of a sequence. Frame 0 always starts a shot and frame 1 never does; later
// frames are hard cuts when epsilon exceeds the high threshold, or become
// deferred candidates when epsilon and energy pass their lower thresholds. A
// candidate is decided when the next candidate arrives or the sequence ends,
// so an item yields zero, one or two result items. The front end accepts one
// item every cycle while its four-entry queue has room; results leave through
// one registered output port at one per cycle while the receiver is ready, so
// an item that yields two results holds the port for both. Each result passes
// through the queue and the output register before it is valid on the output.
// Configuration registers sit on an APB port at byte addresses 0, 4, 8 and 12;
// the user must write them only while the block is idle; the block does not enforce it.
module video_shot_boundary_detector_unit
    import vsbd_pkg::*;
#(
    parameter int INDEX_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Input stream of frame feature items.
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // [23:0] epsilon, [47:24] energy_diff
    input  wire logic        i_s_tlast,   // end_of_sequence

    // Output stream of decision items.
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [31:0] o_m_tdata,   // [23:0] frame_index, [24] new_shot,
                                          // [25] was_uncertain, [31:26] zero
    output      logic        o_m_tlast,   // last_of_run

    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    t_cfg      r_cfg;
    t_pkt      front_pkt, queue_pkt;
    logic      front_push, back_pop;
    t_push_ctl push_ctl;
    t_pop_ctl  pop_ctl;
    t_res      out_res;
    logic      cfg_write;

    // Configuration registers. The word address is paddr[3:2]; the byte
    // offset within the word is ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_eps   <= 24'sd10240;
            r_cfg.low_eps    <= 24'sd3840;
            r_cfg.energy     <= 24'sd5120;
            r_cfg.min_length <= 8'd30;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_HIGH_EPS:   r_cfg.high_eps   <= $signed(pwdata[FIELD_BITS-1:0]);
                REG_LOW_EPS:    r_cfg.low_eps    <= $signed(pwdata[FIELD_BITS-1:0]);
                REG_ENERGY:     r_cfg.energy     <= $signed(pwdata[FIELD_BITS-1:0]);
                REG_MIN_LENGTH: r_cfg.min_length <= pwdata[FPS_BITS-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HIGH_EPS:   prdata = {8'd0, r_cfg.high_eps};
            REG_LOW_EPS:    prdata = {8'd0, r_cfg.low_eps};
            REG_ENERGY:     prdata = {8'd0, r_cfg.energy};
            REG_MIN_LENGTH: prdata = {24'd0, r_cfg.min_length};
            default:        prdata = '0;
        endcase
    end

    // The front end classifies each frame and holds the sequence state.
    vsbd_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_valid           (i_s_tvalid),
        .o_ready           (o_s_tready),
        .i_epsilon         (i_s_tdata[23:0]),
        .i_energy_diff     (i_s_tdata[47:24]),
        .i_end_of_sequence (i_s_tlast),
        .i_full            (push_ctl.full),
        .o_push            (front_push),
        .o_pkt             (front_pkt)
    );

    // Each queue entry holds the one or two results of one input item.
    vsbd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (front_push),
        .i_pkt      (front_pkt),
        .i_pop      (back_pop),
        .o_push_ctl (push_ctl),
        .o_pop_ctl  (pop_ctl),
        .o_pkt      (queue_pkt)
    );

    // The back end sends the results out one at a time and marks the last.
    vsbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (queue_pkt),
        .i_empty (pop_ctl.empty),
        .o_pop   (back_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {6'd0, out_res.was_uncertain, out_res.new_shot, out_res.frame_index};

    a_pop_matches_ctl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_ctl.pop |-> !pop_ctl.empty)
        else $error("result queue popped while empty");

    a_ready_tracks_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == !push_ctl.full)
        else $error("input ready disagrees with queue room");

endmodule

`default_nettype wire

@@ src/vsbd_front.sv @@
`default_nettype none

module vsbd_front
    import vsbd_pkg::*;
#(
    parameter int INDEX_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_valid,
    output      logic                  o_ready,
    input  wire logic [FIELD_BITS-1:0] i_epsilon,
    input  wire logic [FIELD_BITS-1:0] i_energy_diff,
    input  wire logic                  i_end_of_sequence,
    input  wire logic                  i_full,
    output      logic                  o_push,
    output      t_pkt                  o_pkt
);

    localparam int W = INDEX_BITS + 1;
    localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

    logic [INDEX_BITS-1:0] r_frame_cnt, n_frame_cnt;
    logic [INDEX_BITS-1:0] r_last_cut, n_last_cut;
    logic                  r_pend_valid, n_pend_valid;
    logic [INDEX_BITS-1:0] r_pend_index, n_pend_index;
    logic [INDEX_BITS-1:0] r_pend_dist, n_pend_dist;

    logic                  accept;
    logic                  is_first, is_second, hard_cut, candidate;
    logic                  first_valid, eos_valid, ok_next, ok_end;
    logic [W-1:0]          fps_w;
    logic [FIELD_BITS-1:0] idx_out, pend_out, new_pend_out;
    t_res                  res_now, res_end;

    // Zero-extend then take the low 24 bits, so any INDEX_BITS maps cleanly.
    function automatic logic [FIELD_BITS-1:0] to_field(input logic [INDEX_BITS-1:0] v);
        logic [INDEX_BITS+FIELD_BITS-1:0] ext;
        ext = {{FIELD_BITS{1'b0}}, v};
        return ext[FIELD_BITS-1:0];
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign fps_w   = {{(W-FPS_BITS){1'b0}}, i_cfg.min_length};

    always_comb begin
        is_first  = (r_frame_cnt == '0);
        is_second = (r_frame_cnt == INDEX_BITS'(1));
        hard_cut  = !is_first && !is_second && ($signed(i_epsilon) > i_cfg.high_eps);
        candidate = !is_first && !is_second && !hard_cut
                    && ($signed(i_epsilon) >= i_cfg.low_eps)
                    && ($signed(i_energy_diff) >= i_cfg.energy);

        n_pend_valid = candidate ? 1'b1 : r_pend_valid;
        n_pend_index = candidate ? r_frame_cnt : r_pend_index;
        n_pend_dist  = candidate ? (r_frame_cnt - r_last_cut) : r_pend_dist;

        // A pending candidate released by the next candidate.
        ok_next = ({1'b0, r_pend_dist} >= fps_w)
                  && ({1'b0, r_frame_cnt - r_pend_index} >= fps_w);
        // The candidate still pending when the sequence ends.
        ok_end  = ({1'b0, n_pend_dist} >= fps_w)
                  && (({1'b0, n_pend_index} + fps_w) <= ({1'b0, r_frame_cnt} + W'(1)));

        idx_out      = to_field(r_frame_cnt);
        pend_out     = to_field(r_pend_index);
        new_pend_out = to_field(n_pend_index);

        res_now.frame_index   = candidate ? pend_out : idx_out;
        res_now.new_shot      = candidate ? ok_next : (is_first || hard_cut);
        res_now.was_uncertain = candidate;

        res_end.frame_index   = new_pend_out;
        res_end.new_shot      = ok_end;
        res_end.was_uncertain = 1'b1;

        first_valid = !candidate || r_pend_valid;
        eos_valid   = i_end_of_sequence && n_pend_valid;

        if (first_valid) begin
            o_pkt.first  = res_now;
            o_pkt.second = res_end;
            o_pkt.two    = eos_valid;
        end else begin
            o_pkt.first  = res_end;
            o_pkt.second = res_end;
            o_pkt.two    = 1'b0;
        end
        o_push = accept && (first_valid || eos_valid);

        n_frame_cnt = r_frame_cnt;
        n_last_cut  = hard_cut ? r_frame_cnt : r_last_cut;
        if (i_end_of_sequence) begin
            n_frame_cnt  = '0;
            n_last_cut   = '0;
            n_pend_valid = 1'b0;
        end else if (r_frame_cnt != IDX_MAX) begin
            n_frame_cnt = r_frame_cnt + INDEX_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cnt  <= '0;
            r_last_cut   <= '0;
            r_pend_valid <= 1'b0;
        end else if (accept) begin
            r_frame_cnt  <= n_frame_cnt;
            r_last_cut   <= n_last_cut;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_index <= n_pend_index;
            r_pend_dist  <= n_pend_dist;
        end
    end

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_end_of_sequence |=> !r_pend_valid && r_frame_cnt == '0 && r_last_cut == '0)
        else $error("sequence state not cleared after final frame");

    a_cut_not_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_cut <= r_frame_cnt)
        else $error("last cut index lies beyond the frame counter");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("push into a full queue");

endmodule

`default_nettype wire

@@ src/vsbd_fifo.sv @@
`default_nettype none

module vsbd_fifo
    import vsbd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_pkt      i_pkt,
    input  wire logic      i_pop,
    output      t_push_ctl o_push_ctl,
    output      t_pop_ctl  o_pop_ctl,
    output      t_pkt      o_pkt
);

    t_pkt                r_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                full, empty, do_push, do_pop;

    assign full    = (r_count == CNT_BITS'(FIFO_DEPTH));
    assign empty   = (r_count == '0);
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !empty;

    assign o_push_ctl.push = i_push;
    assign o_push_ctl.full = full;
    assign o_pop_ctl.pop   = i_pop;
    assign o_pop_ctl.empty = empty;
    assign o_pkt           = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_BITS'(1);
                2'b01:   r_count <= r_count - CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_ptr == PTR_BITS'(r_rd_ptr + r_count[PTR_BITS-1:0]))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

@@ src/vsbd_back.sv @@
`default_nettype none

module vsbd_back
    import vsbd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_pkt        i_pkt,
    input  wire logic        i_empty,
    output      logic        o_pop,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      t_res        o_res,
    output      logic        o_last
);

    logic r_valid;
    logic r_last;
    t_res r_res;
    logic r_sec_pend;
    t_res r_sec;
    logic can_load;

    assign can_load = !r_valid || i_ready;
    assign o_pop    = can_load && !r_sec_pend && !i_empty;
    assign o_valid  = r_valid;
    assign o_res    = r_res;
    assign o_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_sec_pend <= 1'b0;
        end else if (can_load) begin
            if (r_sec_pend) begin
                r_valid    <= 1'b1;
                r_sec_pend <= 1'b0;
            end else if (!i_empty) begin
                r_valid    <= 1'b1;
                r_sec_pend <= i_pkt.two;
            end else begin
                r_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load) begin
            if (r_sec_pend) begin
                r_res  <= r_sec;
                r_last <= 1'b1;
            end else if (!i_empty) begin
                r_res  <= i_pkt.first;
                r_last <= !i_pkt.two;
                r_sec  <= i_pkt.second;
            end
        end
    end

    a_second_behind_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec_pend |-> r_valid && !r_last)
        else $error("second result held without a first one on the port");

    a_no_pop_while_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec_pend |-> !o_pop)
        else $error("queue popped while a second result is still held");

endmodule

`default_nettype wire
